[rtl/rida_pkg.sv]
// Shared types, constants and helpers for the recycling id allocator.
// No dependencies.
`timescale 1ns / 1ps

package rida_pkg;

    localparam int DATA_W          = 64;
    localparam int NUM_CLASSES_DEF = 4;
    localparam int FREE_DEPTH_DEF  = 16;
    localparam int CLASS_IN_W      = 2;
    localparam int BYTES_W         = 4;
    localparam int TDATA_IN_W      = 72;
    localparam int TDATA_OUT_W     = 72;

    localparam logic [DATA_W-1:0] ID_RESET = 64'd1;

    // request codes; the fourth code means nothing and changes no state
    localparam logic [1:0] FN_GET       = 2'd0;
    localparam logic [1:0] FN_GET_FRESH = 2'd1;
    localparam logic [1:0] FN_PUT       = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLS,
        ST_FREE
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] id_out;
        logic              recycled;
        logic              overflow;
    } t_result;

    // byte count 0 gives an empty mask, 8 and above saturate to all ones
    function automatic logic [DATA_W-1:0] byte_mask(input logic [BYTES_W-1:0] nbytes);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (nbytes > BYTES_W'(i)) begin
                m[i*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

[rtl/rida_class_mem.sv]
// Per-class state memory: next id counter and free queue pointers.
// Valid bits per entry make an unwritten entry read as the reset value.
`timescale 1ns / 1ps

module rida_class_mem
    import rida_pkg::*;
#(
    parameter int              DEPTH   = NUM_CLASSES_DEF,
    parameter int              AW      = 2,
    parameter int              DW      = 74,
    parameter logic [DW-1:0]   RST_VAL = '0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0] r_rd_data;
    logic          r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : RST_VAL;

endmodule

[rtl/rida_free_mem.sv]
// Free id store shared by all classes, one slot range per class.
// Synchronous single write / single read port, contents undefined after reset.
`timescale 1ns / 1ps

module rida_free_mem
    import rida_pkg::*;
#(
    parameter int DEPTH = NUM_CLASSES_DEF * FREE_DEPTH_DEF,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/recycling_id_allocator_core.sv]
// Recycling id allocator: per-class counter with a FIFO of returned ids.
// Each request passes a class-state read, then an optional free-store read (recycled get),
// then write-back with the result registered; a step that loads the result stalls while the
// output still holds an untaken result. One request in flight at a time.
// Reset (synchronous, active low): counters read as 1, queues empty; free store undefined.
// Uses rida_pkg, rida_class_mem, rida_free_mem.
`timescale 1ns / 1ps

module recycling_id_allocator_core
    import rida_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int FREE_DEPTH  = FREE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // [1:0] func, [3:2] id_class, [67:4] id_value, [71:68] id_bytes
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [63:0] id_out, [64] recycled, [65] overflow, [71:66] zero
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready
);

    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SLOT_W = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(FREE_DEPTH + 1);
    localparam int FDEPTH = NUM_CLASSES * FREE_DEPTH;
    localparam int FA_W   = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
    localparam int CS_W   = DATA_W + 2 * SLOT_W + CNT_W;
    localparam logic [CS_W-1:0] CS_RST = {ID_RESET, {(CS_W - DATA_W){1'b0}}};

    function automatic logic [SLOT_W-1:0] slot_adv(input logic [SLOT_W-1:0] s);
        logic [SLOT_W:0] inc;
        inc = {1'b0, s} + (SLOT_W+1)'(1);
        return (inc >= (SLOT_W+1)'(FREE_DEPTH)) ? '0 : inc[SLOT_W-1:0];
    endfunction

    // input field split
    logic [1:0]          in_func;
    logic [CLASS_IN_W-1:0] in_class;
    logic [DATA_W-1:0]   in_value;
    logic [BYTES_W-1:0]  in_bytes;
    logic [DATA_W-1:0]   in_mask;
    logic [CLS_W-1:0]    in_cls_idx;

    assign in_func    = s_axis_tdata[1:0];
    assign in_class   = s_axis_tdata[3:2];
    assign in_value   = s_axis_tdata[67:4];
    assign in_bytes   = s_axis_tdata[71:68];
    assign in_mask    = byte_mask(in_bytes);
    assign in_cls_idx = CLS_W'(in_class);

    t_state             r_state, n_state;
    logic [1:0]         r_func;
    logic               r_in_range;
    logic [CLS_W-1:0]   r_cls;
    logic [DATA_W-1:0]  r_value;
    logic [DATA_W-1:0]  r_mask;
    logic [FA_W-1:0]    r_base;
    logic               r_out_valid;
    t_result            r_out;
    t_result            n_out;

    logic accept;
    logic out_free;
    logic out_load;

    // class state memory ports
    logic [CS_W-1:0]    cs_rd;
    logic               cs_wr_en;
    logic [CS_W-1:0]    cs_wr_data;
    logic [DATA_W-1:0]  cs_next;
    logic [SLOT_W-1:0]  cs_head;
    logic [SLOT_W-1:0]  cs_tail;
    logic [CNT_W-1:0]   cs_count;

    // free store ports
    logic               fr_rd_en;
    logic [FA_W-1:0]    fr_rd_addr;
    logic [DATA_W-1:0]  fr_rd_data;
    logic               fr_wr_en;
    logic [FA_W-1:0]    fr_wr_addr;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign cs_next  = cs_rd[CS_W-1 -: DATA_W];
    assign cs_head  = cs_rd[2*SLOT_W+CNT_W-1 -: SLOT_W];
    assign cs_tail  = cs_rd[SLOT_W+CNT_W-1 -: SLOT_W];
    assign cs_count = cs_rd[CNT_W-1:0];

    assign fr_rd_addr = FA_W'(r_base + FA_W'(cs_head));
    assign fr_wr_addr = FA_W'(r_base + FA_W'(cs_tail));

    rida_class_mem #(
        .DEPTH   (NUM_CLASSES),
        .AW      (CLS_W),
        .DW      (CS_W),
        .RST_VAL (CS_RST)
    ) u_class_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (in_cls_idx),
        .o_rd_data (cs_rd),
        .i_wr_en   (cs_wr_en),
        .i_wr_addr (r_cls),
        .i_wr_data (cs_wr_data)
    );

    rida_free_mem #(
        .DEPTH (FDEPTH),
        .AW    (FA_W)
    ) u_free_mem (
        .i_clk     (i_clk),
        .i_rd_en   (fr_rd_en),
        .i_rd_addr (fr_rd_addr),
        .o_rd_data (fr_rd_data),
        .i_wr_en   (fr_wr_en),
        .i_wr_addr (fr_wr_addr),
        .i_wr_data (r_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func     <= in_func;
            r_in_range <= (int'(in_class) < NUM_CLASSES);
            r_cls      <= in_cls_idx;
            r_mask     <= in_mask;
            r_value    <= in_value & in_mask;
            r_base     <= FA_W'(FA_W'(in_cls_idx) * FA_W'(FREE_DEPTH));
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        n_out         = '0;
        cs_wr_en      = 1'b0;
        cs_wr_data    = cs_rd;
        fr_rd_en      = 1'b0;
        fr_wr_en      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_CLS;
                end
            end
            ST_CLS: begin
                priority if (!r_in_range || (r_func != FN_GET && r_func != FN_GET_FRESH
                                             && r_func != FN_PUT)) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end else if (r_func == FN_GET && cs_count != '0) begin
                    // recycled id: fetch the queue head first
                    fr_rd_en = 1'b1;
                    n_state  = ST_FREE;
                end else if (r_func == FN_GET || r_func == FN_GET_FRESH) begin
                    if (out_free) begin
                        out_load     = 1'b1;
                        n_out.id_out = cs_next & r_mask;
                        cs_wr_en     = 1'b1;
                        cs_wr_data   = {cs_next + DATA_W'(1), cs_head, cs_tail, cs_count};
                        n_state      = ST_IDLE;
                    end
                end else begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = ST_IDLE;
                        if (cs_count == CNT_W'(FREE_DEPTH)) begin
                            n_out.overflow = 1'b1;
                        end else begin
                            fr_wr_en   = 1'b1;
                            cs_wr_en   = 1'b1;
                            cs_wr_data = {cs_next, cs_head, slot_adv(cs_tail),
                                          cs_count + CNT_W'(1)};
                        end
                    end
                end
            end
            ST_FREE: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    n_out.id_out   = fr_rd_data & r_mask;
                    n_out.recycled = 1'b1;
                    cs_wr_en       = 1'b1;
                    cs_wr_data     = {cs_next, slot_adv(cs_head), cs_tail,
                                      cs_count - CNT_W'(1)};
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_OUT_W - DATA_W - 2){1'b0}}, r_out.overflow,
                            r_out.recycled, r_out.id_out};

    // output register is never overwritten while a result is still pending
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || m_axis_tready))
        else $error("result overwritten before transfer");

    // an accepted request always goes to the class-state read
    a_accept_to_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_CLS))
        else $error("accepted request did not reach class read");

    // recycled results only come from the free-store read step
    a_recycled_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_out.recycled) |-> (r_state == ST_FREE))
        else $error("recycled result outside free read");

    // no result is both recycled and an overflowed put
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.recycled && r_out.overflow))
        else $error("recycled and overflow both set");

    // free store is never read and written in one cycle
    a_free_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fr_rd_en && fr_wr_en))
        else $error("free store read and write collide");

endmodule

[bench/recycling_id_allocator_core_test.sv]
// Self-checking bench for recycling_id_allocator_core: a directed table, then random
// put/get bursts per class, with every result compared against a typed-in value or a behavioural predictor.
// Depends on rida_pkg and the core; needs no files or arguments.
`timescale 1ns / 1ps

module recycling_id_allocator_core_test
    import rida_pkg::*;
();

    localparam logic [1:0] FN_NONE   = 2'd3;     // unused code, result all zero
    localparam int         RAND_REQS = 1450;
    localparam int         HOLD_LEN  = 300;
    localparam int         LIMIT     = 200000;

    typedef struct packed {
        logic [1:0]  fn;
        logic [1:0]  cls;
        logic [63:0] value;
        logic [3:0]  nbytes;
    } t_alloc_req;

    typedef struct packed {
        logic       known;                       // expected result typed in below
        t_alloc_req req;
        t_result    res;
    } t_dir_row;

    localparam int DIR_ROWS = 22;

    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
    localparam t_result     ZERO_RES = '{64'd0, 1'b0, 1'b0};

    t_dir_row dir_rows [0:DIR_ROWS-1] = '{
        '{1'b1, '{FN_GET,       2'd0, 64'd0, 4'd8},                 '{64'd1, 1'b0, 1'b0}},
        '{1'b1, '{FN_GET_FRESH, 2'd1, 64'd0, 4'd8},                 '{64'd1, 1'b0, 1'b0}},
        '{1'b1, '{FN_GET,       2'd0, 64'd0, 4'd8},                 '{64'd2, 1'b0, 1'b0}},
        '{1'b1, '{FN_PUT,       2'd2, ALL_ONES, 4'd8},              ZERO_RES},
        '{1'b1, '{FN_PUT,       2'd2, 64'h0123_4567_89ab_cdef, 4'd3}, ZERO_RES},
        '{1'b1, '{FN_GET,       2'd2, 64'd0, 4'd8},                 '{ALL_ONES, 1'b1, 1'b0}},
        // byte count above eight saturates
        '{1'b0, '{FN_GET,       2'd2, 64'd0, 4'd15},                ZERO_RES},
        // zero bytes still burns a counter value
        '{1'b1, '{FN_GET,       2'd2, 64'd0, 4'd0},                 ZERO_RES},
        '{1'b0, '{FN_GET,       2'd2, 64'd0, 4'd8},                 ZERO_RES},
        '{1'b1, '{FN_NONE,      2'd3, ALL_ONES, 4'd8},              ZERO_RES},
        '{1'b1, '{FN_PUT,       2'd3, 64'd0, 4'd8},                 ZERO_RES},
        // fresh get leaves the queued id alone
        '{1'b1, '{FN_GET_FRESH, 2'd3, 64'd0, 4'd8},                 '{64'd1, 1'b0, 1'b0}},
        '{1'b1, '{FN_GET,       2'd3, ALL_ONES, 4'd1},              '{64'd0, 1'b1, 1'b0}},
        '{1'b1, '{FN_PUT,       2'd1, ALL_ONES, 4'd0},              ZERO_RES},
        '{1'b1, '{FN_GET,       2'd1, 64'd0, 4'd8},                 '{64'd0, 1'b1, 1'b0}},
        '{1'b0, '{FN_GET,       2'd1, 64'd0, 4'd2},                 ZERO_RES},
        '{1'b0, '{FN_PUT,       2'd0, 64'h8000_0000_0000_0001, 4'd7}, ZERO_RES},
        '{1'b0, '{FN_GET,       2'd0, 64'd0, 4'd8},                 ZERO_RES},
        '{1'b0, '{FN_GET,       2'd0, 64'd0, 4'd9},                 ZERO_RES},
        '{1'b1, '{FN_NONE,      2'd0, 64'd0, 4'd0},                 ZERO_RES},
        '{1'b0, '{FN_PUT,       2'd3, ALL_ONES, 4'd12},             ZERO_RES},
        '{1'b0, '{FN_GET,       2'd3, 64'd0, 4'd8},                 ZERO_RES}
    };

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;

    // predictor state
    logic [63:0] ctr_next  [NUM_CLASSES_DEF];
    logic [63:0] ret_ids   [NUM_CLASSES_DEF][FREE_DEPTH_DEF];
    int unsigned ret_head  [NUM_CLASSES_DEF];
    int unsigned ret_tail  [NUM_CLASSES_DEF];
    int unsigned ret_fill  [NUM_CLASSES_DEF];

    t_result     pending_ids[$];
    int          err_cnt     = 0;
    int          n_results   = 0;
    int          n_recycled  = 0;
    int          n_overflow  = 0;
    int          n_reqs      = 0;
    int          cycles      = 0;
    int          hold_left   = 0;
    logic        rx_hold_done = 1'b0;
    logic        want_rx_hold = 1'b0;
    logic        steady       = 1'b0;

    recycling_id_allocator_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result predict_alloc(input t_alloc_req req);
        t_result     r;
        logic [63:0] keep;
        int unsigned c;
        r = '0;
        c = req.cls;
        if (req.nbytes == 4'd0)
            keep = '0;
        else if (req.nbytes >= 4'd8)
            keep = '1;
        else
            keep = (64'd1 << (8 * req.nbytes)) - 64'd1;
        if (c < NUM_CLASSES_DEF) begin
            if (req.fn == FN_GET && ret_fill[c] != 0) begin
                r.id_out   = ret_ids[c][ret_head[c]] & keep;
                r.recycled = 1'b1;
                ret_head[c] = (ret_head[c] + 1) % FREE_DEPTH_DEF;
                ret_fill[c]--;
            end else if (req.fn == FN_GET || req.fn == FN_GET_FRESH) begin
                r.id_out    = ctr_next[c] & keep;
                ctr_next[c] = ctr_next[c] + 64'd1;
            end else if (req.fn == FN_PUT) begin
                if (ret_fill[c] >= FREE_DEPTH_DEF) begin
                    r.overflow = 1'b1;
                end else begin
                    ret_ids[c][ret_tail[c]] = req.value & keep;
                    ret_tail[c] = (ret_tail[c] + 1) % FREE_DEPTH_DEF;
                    ret_fill[c]++;
                end
            end
        end
        return r;
    endfunction

    // offer one request, hold it until the transfer, then log what must come back
    task automatic send_req(input t_alloc_req req, input logic known, input t_result typed);
        t_result r;
        while (!steady && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {req.nbytes, req.value, req.cls, req.fn};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_alloc(req);
        pending_ids.push_back(known ? typed : r);
        n_reqs++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_ids.size() != 0)
            @(posedge i_clk);
    endtask

    // receiver: random back-pressure, one long hold-off, a quiet stretch
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (want_rx_hold && !rx_hold_done) begin
            hold_left     <= HOLD_LEN;
            rx_hold_done  <= 1'b1;
            m_axis_tready <= 1'b0;
        end else if (steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 27);
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_ids.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_ids.size() == 0) begin
                $error("unexpected result transfer: tdata %h", m_axis_tdata);
                err_cnt++;
            end else begin
                want = pending_ids.pop_front();
                if (m_axis_tdata[63:0] !== want.id_out) begin
                    $error("id_out: expected %h, got %h", want.id_out, m_axis_tdata[63:0]);
                    err_cnt++;
                end
                if (m_axis_tdata[64] !== want.recycled) begin
                    $error("recycled: expected %0b, got %0b", want.recycled, m_axis_tdata[64]);
                    err_cnt++;
                end
                if (m_axis_tdata[65] !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, m_axis_tdata[65]);
                    err_cnt++;
                end
                if (want.recycled) n_recycled++;
                if (want.overflow) n_overflow++;
            end
        end
    end

    initial begin
        t_alloc_req  req;
        int          rnd_sent;
        int          burst_len;
        int          mode;
        int          pick;
        logic [1:0]  cls;

        for (int c = 0; c < NUM_CLASSES_DEF; c++) begin
            ctr_next[c] = 64'd1;
            ret_head[c] = 0;
            ret_tail[c] = 0;
            ret_fill[c] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res);
        drain_results();

        // bursts per class: put runs fill (and overflow) a queue, get runs drain it,
        // mixed runs throw every code at every class
        rnd_sent = 0;
        while (rnd_sent < RAND_REQS) begin
            cls       = 2'($urandom_range(3));
            mode      = $urandom_range(9);
            burst_len = $urandom_range(1, 20);
            for (int i = 0; i < burst_len && rnd_sent < RAND_REQS; i++) begin
                req.cls = cls;
                if (mode < 3)
                    req.fn = FN_PUT;
                else if (mode < 6)
                    req.fn = ($urandom_range(4) == 0) ? FN_GET_FRESH : FN_GET;
                else begin
                    req.fn  = 2'($urandom_range(3));
                    req.cls = 2'($urandom_range(3));
                end
                pick = $urandom_range(7);
                if (pick == 0)
                    req.value = '0;
                else if (pick == 1)
                    req.value = '1;
                else
                    req.value = {$urandom, $urandom};
                pick = $urandom_range(9);
                if (pick < 7)
                    req.nbytes = 4'($urandom_range(1, 8));
                else if (pick == 7)
                    req.nbytes = 4'd0;
                else
                    req.nbytes = 4'($urandom_range(9, 15));
                send_req(req, 1'b0, ZERO_RES);
                rnd_sent++;
                if (rnd_sent == 300)
                    want_rx_hold <= 1'b1;
                if (rnd_sent == 700)
                    drain_results();
                steady <= (rnd_sent >= 900 && rnd_sent < 1100);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("%0d requests (all four codes, byte counts 0..15, every class), %0d results",
                 n_reqs, n_results);
        $display("%0d served from the free queues, %0d puts dropped on a full queue",
                 n_recycled, n_overflow);
        if (err_cnt == 0 && pending_ids.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
